// ===== sv/qlm_pkg.sv =====
// Shared types, widths and the arctangent table for the quaternion log map unit.
package qlm_pkg;

    localparam int DATA_W       = 16;
    localparam int IN_FRAC      = DATA_W - 2;
    localparam int OUT_FRAC     = DATA_W - 3;
    localparam int LIMIT_W      = 10;
    localparam int ADDR_W       = 3;
    localparam int PDATA_W      = 32;
    localparam int NORM_TOP     = 28;
    localparam int NORM_W       = NORM_TOP + 1;
    localparam int POS_W        = 6;
    localparam int SHIFT_W      = 64;
    localparam int SQ_W         = 2 * NORM_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int CMP_W        = ROOT_W + LIMIT_W + IN_FRAC;
    localparam int CORDIC_STEPS = 28;
    localparam int COR_W        = ROOT_W + 4;
    localparam int ANG_W        = 33;
    localparam int ANGU_W       = ANG_W - 2;
    localparam int ANG_FRAC     = 30;
    localparam int DEN_W        = ROOT_W + ANG_FRAC - OUT_FRAC;
    localparam int NUM_W        = ANGU_W + NORM_W + 2;
    localparam int QUOT_W       = OUT_FRAC + 3;

    localparam logic [ADDR_W-1:0] REG_SMALL_ANGLE_LIMIT = 3'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
    } rot_t;

    typedef struct packed {
        logic [3:0][NORM_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
    } side_t;

    typedef struct packed {
        logic signed [COR_W-1:0] xv;
        logic signed [COR_W-1:0] yv;
        logic signed [ANG_W-1:0] ang;
        logic                    small_sel;
        logic [ROOT_W-1:0]       nq;
        logic [ROOT_W-1:0]       nv;
        logic [2:0][NORM_W-1:0]  vmag;
        logic [2:0]              neg;
        logic                    zero;
    } cor_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]      den;
        logic [2:0]            neg;
        logic                  zero;
    } num_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } sign_t;

    function automatic logic [31:0] atan_val(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000007;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qlm_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qlm_isqrt #(
    parameter int IN_W  = 60,
    parameter int OUT_W = 30
) (
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  din,
    output logic [OUT_W-1:0] root
);

    localparam int EXT_W = IN_W + 2;

    logic [IN_W-1:0]  rem_reg [OUT_W];
    logic [OUT_W-1:0] q_reg   [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;
        logic [IN_W-1:0]  rem_in;
        logic [OUT_W-1:0] q_in;
        logic [EXT_W-1:0] test;
        logic [EXT_W-1:0] rem_ext;
        logic [IN_W-1:0]  rem_next;
        logic [OUT_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign rem_in = din;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            test    = (EXT_W'(q_in) << (B + 1)) + (EXT_W'(1) << (2 * B));
            rem_ext = EXT_W'(rem_in);
            if (rem_ext >= test)
            begin
                rem_next = rem_in - test[IN_W-1:0];
                q_next   = q_in | (OUT_W'(1) << B);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign root = q_reg[OUT_W-1];

endmodule

// ===== sv/qlm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qlm_div #(
    parameter int NUM_W  = 62,
    parameter int DEN_W  = 47,
    parameter int QUOT_W = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUOT_W-1:0] quot
);

    localparam int EXT_W = NUM_W + QUOT_W;

    logic [NUM_W-1:0]  rem_reg [QUOT_W];
    logic [DEN_W-1:0]  den_reg [QUOT_W];
    logic [QUOT_W-1:0] q_reg   [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int B = QUOT_W - 1 - k;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] q_in;
        logic [EXT_W-1:0]  dsh;
        logic [NUM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            dsh = EXT_W'(den_in) << B;
            if (EXT_W'(rem_in) >= dsh)
            begin
                rem_next = rem_in - dsh[NUM_W-1:0];
                q_next   = q_in | (QUOT_W'(1) << B);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign quot = q_reg[QUOT_W-1];

endmodule

// ===== sv/quaternion_log_map_unit.sv =====
// Top level: quaternion to rotation vector log map, fully pipelined.
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, in_data      | request in, stall out
//  out     | out_valid, out_stall, out_data   | request out, stall in
//  cfg     | psel/penable/pwrite/paddr/pwdata | APB write/read, pready tied high
//
// One request per cycle while out is not stalled; the path holds the 30-stage square root,
// the 28-stage CORDIC and the 16-stage divider.
// rst_n clears valid bits and sets small_angle_limit to 1; data regs are not reset.
// A stall on out while out_valid is high freezes every stage together; in_stall follows it.
module quaternion_log_map_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  qlm_pkg::quat_t              in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output qlm_pkg::rot_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qlm_pkg::ADDR_W-1:0]  paddr,
    input  logic [qlm_pkg::PDATA_W-1:0] pwdata,
    output logic [qlm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int DW   = qlm_pkg::DATA_W;
    localparam int NW   = qlm_pkg::NORM_W;
    localparam int RW   = qlm_pkg::ROOT_W;
    localparam int CS   = qlm_pkg::CORDIC_STEPS;
    localparam int QW   = qlm_pkg::QUOT_W;
    localparam int DEC  = 4 + RW;
    localparam int RND  = DEC + CS + 2;
    localparam int NST  = RND + QW + 2;

    logic adv;
    logic [NST-1:0] valid_reg;

    assign adv       = !(valid_reg[NST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    // config register
    logic [qlm_pkg::LIMIT_W-1:0] limit_reg;
    logic                        reg_sel;

    assign reg_sel = (paddr[qlm_pkg::ADDR_W-1:2] == qlm_pkg::REG_SMALL_ANGLE_LIMIT[2]);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? qlm_pkg::PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= qlm_pkg::LIMIT_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            limit_reg <= pwdata[qlm_pkg::LIMIT_W-1:0];
    end

    // stage 1: magnitudes and signs
    logic [3:0][DW-1:0] s1_mag_reg;
    logic [3:0]         s1_neg_reg;
    logic [3:0][DW-1:0] raw;

    assign raw = {in_data.quat_z, in_data.quat_y, in_data.quat_x, in_data.quat_w};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s1_neg_reg[k] <= raw[k][DW-1];
                s1_mag_reg[k] <= raw[k][DW-1] ? (DW'(0) - raw[k]) : raw[k];
            end
        end
    end

    // stage 2: block scaling to [2^28, 2^29)
    qlm_pkg::side_t s2_next, s2_reg;
    logic [DW-1:0]               mag_or;
    logic [qlm_pkg::POS_W-1:0]   top_pos;
    logic [qlm_pkg::SHIFT_W-1:0] wide;

    always_comb
    begin
        mag_or  = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2] | s1_mag_reg[3];
        top_pos = '0;
        for (int b = 0; b < DW; b++)
        begin
            if (mag_or[b])
                top_pos = qlm_pkg::POS_W'(b);
        end
        s2_next.zero = (mag_or == '0);
        for (int k = 0; k < 3; k++)
            s2_next.neg[k] = s1_neg_reg[k+1] ^ s1_neg_reg[0];
        for (int k = 0; k < 4; k++)
        begin
            wide = qlm_pkg::SHIFT_W'(s1_mag_reg[k]);
            if (top_pos <= qlm_pkg::POS_W'(qlm_pkg::NORM_TOP))
                wide = wide << (qlm_pkg::POS_W'(qlm_pkg::NORM_TOP) - top_pos);
            else
                wide = wide >> (top_pos - qlm_pkg::POS_W'(qlm_pkg::NORM_TOP));
            s2_next.mag[k] = wide[NW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    // stage 3: squares
    logic [3:0][qlm_pkg::SQ_W-1:0] s3_sq_reg;
    qlm_pkg::side_t                s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s2_reg;
            for (int k = 0; k < 4; k++)
                s3_sq_reg[k] <= qlm_pkg::SQ_W'(s2_reg.mag[k]) * qlm_pkg::SQ_W'(s2_reg.mag[k]);
        end
    end

    // stage 4: vector and full norm squared
    logic [qlm_pkg::SUM_W-1:0] s4_nv2_reg, s4_nq2_reg, nv2_sum;
    qlm_pkg::side_t            s4_reg;

    assign nv2_sum = qlm_pkg::SUM_W'(s3_sq_reg[1]) + qlm_pkg::SUM_W'(s3_sq_reg[2])
                   + qlm_pkg::SUM_W'(s3_sq_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg     <= s3_reg;
            s4_nv2_reg <= nv2_sum;
            s4_nq2_reg <= nv2_sum + qlm_pkg::SUM_W'(s3_sq_reg[0]);
        end
    end

    // square roots
    logic [RW-1:0]  root_v, root_q;
    qlm_pkg::side_t side_pipe_reg [RW];

    qlm_isqrt #(.IN_W(qlm_pkg::SUM_W), .OUT_W(RW)) u_sqrt_v (
        .clk  (clk),
        .en   (adv),
        .din  (s4_nv2_reg),
        .root (root_v)
    );

    qlm_isqrt #(.IN_W(qlm_pkg::SUM_W), .OUT_W(RW)) u_sqrt_q (
        .clk  (clk),
        .en   (adv),
        .din  (s4_nq2_reg),
        .root (root_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_pipe_reg[0] <= s4_reg;
            for (int i = 1; i < RW; i++)
                side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    // decision stage: small-angle test, CORDIC seed
    qlm_pkg::cor_t              dec_next, dec_reg;
    qlm_pkg::side_t             side_sq;
    logic [qlm_pkg::CMP_W-1:0]  nv_scaled, lim_prod;

    assign side_sq = side_pipe_reg[RW-1];

    always_comb
    begin
        nv_scaled          = qlm_pkg::CMP_W'(root_v) << qlm_pkg::IN_FRAC;
        lim_prod           = qlm_pkg::CMP_W'(limit_reg) * qlm_pkg::CMP_W'(root_q);
        dec_next.small_sel = (root_v == '0) || (nv_scaled < lim_prod);
        dec_next.xv        = qlm_pkg::COR_W'(side_sq.mag[0]);
        dec_next.yv        = qlm_pkg::COR_W'(root_v);
        dec_next.ang       = '0;
        dec_next.nq        = root_q;
        dec_next.nv        = root_v;
        for (int k = 0; k < 3; k++)
            dec_next.vmag[k] = side_sq.mag[k+1];
        dec_next.neg       = side_sq.neg;
        dec_next.zero      = side_sq.zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dec_reg <= dec_next;
    end

    // CORDIC vectoring, one iteration per stage
    qlm_pkg::cor_t cor_reg [CS];

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        qlm_pkg::cor_t                 c_in, c_next;
        logic signed [qlm_pkg::COR_W-1:0] dx, dy;
        logic signed [qlm_pkg::ANG_W-1:0] da;

        if (i == 0) begin : g_first
            assign c_in = dec_reg;
        end else begin : g_rest
            assign c_in = cor_reg[i-1];
        end

        always_comb
        begin
            dx     = c_in.yv >>> i;
            dy     = c_in.xv >>> i;
            da     = qlm_pkg::ANG_W'(qlm_pkg::atan_val(i));
            c_next = c_in;
            if (c_in.yv >= 0)
            begin
                c_next.xv  = c_in.xv + dx;
                c_next.yv  = c_in.yv - dy;
                c_next.ang = c_in.ang + da;
            end
            else
            begin
                c_next.xv  = c_in.xv - dx;
                c_next.yv  = c_in.yv + dy;
                c_next.ang = c_in.ang - da;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                cor_reg[i] <= c_next;
        end
    end

    // numerator and denominator
    qlm_pkg::num_t              num_next, num_reg, rnd_reg;
    qlm_pkg::cor_t              cor_last;
    logic [qlm_pkg::ANGU_W-1:0] ang_u;

    assign cor_last = cor_reg[CS-1];

    always_comb
    begin
        ang_u = cor_last.ang[qlm_pkg::ANG_W-1] ? '0 : cor_last.ang[qlm_pkg::ANGU_W-1:0];
        num_next.neg  = cor_last.neg;
        num_next.zero = cor_last.zero;
        if (cor_last.small_sel)
        begin
            num_next.den = qlm_pkg::DEN_W'(cor_last.nq);
            for (int k = 0; k < 3; k++)
                num_next.num[k] = qlm_pkg::NUM_W'(cor_last.vmag[k]) << (qlm_pkg::OUT_FRAC + 1);
        end
        else
        begin
            num_next.den = qlm_pkg::DEN_W'(cor_last.nv) << (qlm_pkg::ANG_FRAC - qlm_pkg::OUT_FRAC);
            for (int k = 0; k < 3; k++)
                num_next.num[k] = (qlm_pkg::NUM_W'(ang_u) * qlm_pkg::NUM_W'(cor_last.vmag[k])) << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg      <= num_next;
            rnd_reg.den  <= num_reg.den;
            rnd_reg.neg  <= num_reg.neg;
            rnd_reg.zero <= num_reg.zero;
            for (int k = 0; k < 3; k++)
                rnd_reg.num[k] <= num_reg.num[k] + qlm_pkg::NUM_W'(num_reg.den >> 1);
        end
    end

    // division
    logic [2:0][QW-1:0] quot;
    qlm_pkg::sign_t     sign_pipe_reg [QW];

    for (genvar k = 0; k < 3; k++) begin : g_div
        qlm_div #(.NUM_W(qlm_pkg::NUM_W), .DEN_W(qlm_pkg::DEN_W), .QUOT_W(QW)) u_div (
            .clk  (clk),
            .en   (adv),
            .num  (rnd_reg.num[k]),
            .den  (rnd_reg.den),
            .quot (quot[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sign_pipe_reg[0] <= '{neg: rnd_reg.neg, zero: rnd_reg.zero};
            for (int i = 1; i < QW; i++)
                sign_pipe_reg[i] <= sign_pipe_reg[i-1];
        end
    end

    // saturation and output register
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    qlm_pkg::sign_t     sign_last;
    logic [2:0][DW-1:0] res;
    logic [QW-1:0]      sat;
    qlm_pkg::rot_t      out_reg;

    assign sign_last = sign_pipe_reg[QW-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (sign_last.neg[k])
            begin
                sat    = (quot[k] > LIM_NEG) ? LIM_NEG : quot[k];
                res[k] = DW'(QW'(0) - sat);
            end
            else
            begin
                sat    = (quot[k] > LIM_POS) ? LIM_POS : quot[k];
                res[k] = DW'(sat);
            end
            if (sign_last.zero)
                res[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.rot_x <= res[0];
            out_reg.rot_y <= res[1];
            out_reg.rot_z <= res[2];
        end
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_norm_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DEC] |-> (dec_reg.nv <= dec_reg.nq))
        else $error("vector norm exceeds quaternion norm");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_reg[NST-2] && sign_last.zero) |=> (out_data == '0))
        else $error("zero quaternion gave nonzero result");
`endif

endmodule
